[rtl/core/spdm_pkg.sv]
package spdm_pkg;

  localparam int unsigned PEAK_BITS          = 24;
  localparam int unsigned PEAK_FRACTION_BITS = 22;
  localparam int unsigned CHANNEL_BITS       = 8;
  localparam int unsigned SEVEN_BITS         = 7;
  localparam int unsigned CODE_BITS          = 14;
  localparam int unsigned LOG_FRAC_BITS      = 24;
  localparam int unsigned MANT_BITS          = 32;
  localparam int unsigned SHIFT_BITS         = 5;
  localparam int unsigned K_BITS             = 7;
  localparam int unsigned L_BITS             = K_BITS + LOG_FRAC_BITS;
  localparam int unsigned COEF_BITS          = 20;
  localparam int unsigned SLOPE_SPLIT        = 18;
  localparam int unsigned V_BITS             = 64;
  localparam int unsigned V_POINT            = 48;
  localparam int unsigned WHOLE_BITS         = V_BITS - 1 - V_POINT;

  // normalize + one squaring per log2 fraction bit + three scale stages
  localparam int unsigned LATENCY = LOG_FRAC_BITS + 4;

  localparam logic [CODE_BITS-1:0] CODE_MAX = '1;

  localparam logic signed [K_BITS-1:0] K_LOW  = -7'sd16;
  localparam logic signed [K_BITS-1:0] K_HIGH = 7'sd2;

  localparam logic [63:0] SLOPE_Q24 = 64'd25073165058;
  localparam logic signed [COEF_BITS-1:0] SLOPE_LO =
    $signed(COEF_BITS'(SLOPE_Q24 & ((64'd1 << SLOPE_SPLIT) - 64'd1)));
  localparam logic signed [COEF_BITS-1:0] SLOPE_HI =
    $signed(COEF_BITS'(SLOPE_Q24 >> SLOPE_SPLIT));
  localparam logic signed [V_BITS-1:0] OFFSET_Q48 =
    $signed((64'd14893 << 48) + ((64'd7 << 48) / 64'd11));

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] channel_number;
    logic [PEAK_BITS-1:0]    left_peak;
    logic [PEAK_BITS-1:0]    right_peak;
  } peak_in_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] channel_byte;
    logic [SEVEN_BITS-1:0]   left_high_seven;
    logic [SEVEN_BITS-1:0]   left_low_seven;
    logic [SEVEN_BITS-1:0]   right_high_seven;
    logic [SEVEN_BITS-1:0]   right_low_seven;
  } meter_out_t;

  typedef struct packed {
    logic                      zero;
    logic signed [K_BITS-1:0]  k;
    logic [MANT_BITS-1:0]      m;
    logic [LOG_FRAC_BITS-1:0]  frac;
  } lg_t;

endpackage

[rtl/core/spdm_norm.sv]
module spdm_norm import spdm_pkg::*; (
  input  logic                 clk_i,
  input  logic [PEAK_BITS-1:0] peak_i,
  output lg_t                  lg_o
);

  logic [SHIFT_BITS-1:0] e;
  lg_t                   lg_d;
  lg_t                   lg_q;

  always_comb begin
    e = '0;
    for (int i = 0; i < PEAK_BITS; i++) begin
      if (peak_i[i]) begin
        e = SHIFT_BITS'(i);
      end
    end
    lg_d.zero = (peak_i == '0);
    lg_d.k    = $signed({{(K_BITS - SHIFT_BITS){1'b0}}, e}) - K_BITS'(PEAK_FRACTION_BITS);
    lg_d.m    = MANT_BITS'(peak_i) << (SHIFT_BITS'(MANT_BITS - 1) - e);
    lg_d.frac = '0;
  end

  always_ff @(posedge clk_i) begin
    lg_q <= lg_d;
  end

  assign lg_o = lg_q;

endmodule

[rtl/core/spdm_sq_stage.sv]
module spdm_sq_stage import spdm_pkg::*; (
  input  logic clk_i,
  input  lg_t  lg_i,
  output lg_t  lg_o
);

  logic [2*MANT_BITS-1:0] sq;
  logic [MANT_BITS:0]     t;
  lg_t                    lg_d;
  lg_t                    lg_q;

  always_comb begin
    sq        = (2*MANT_BITS)'(lg_i.m) * (2*MANT_BITS)'(lg_i.m);
    t         = sq[2*MANT_BITS-1:MANT_BITS-1];
    lg_d      = lg_i;
    lg_d.frac = {lg_i.frac[LOG_FRAC_BITS-2:0], t[MANT_BITS]};
    lg_d.m    = t[MANT_BITS] ? t[MANT_BITS:1] : t[MANT_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    lg_q <= lg_d;
  end

  assign lg_o = lg_q;

endmodule

[rtl/core/spdm_scale.sv]
module spdm_scale import spdm_pkg::*; (
  input  logic                 clk_i,
  input  lg_t                  lg_i,
  output logic [CODE_BITS-1:0] code_o
);

  typedef struct packed {
    logic zero;
    logic full;
  } force_t;

  logic signed [K_BITS-1:0]          k;
  force_t                            frc_d, frc1_q, frc2_q;
  logic signed [L_BITS-1:0]          l_d, l_q;
  logic signed [L_BITS+COEF_BITS-1:0] plo_d, plo_q;
  logic signed [V_BITS-1:0]          phi;
  logic signed [V_BITS-1:0]          p_d, p_q;
  logic signed [V_BITS-1:0]          v;
  logic [WHOLE_BITS-1:0]             whole;
  logic [CODE_BITS-1:0]              code_d, code_q;

  always_comb begin
    k          = lg_i.k;
    frc_d.zero = lg_i.zero || (k < K_LOW);
    frc_d.full = !lg_i.zero && (k >= K_HIGH);
    l_d        = $signed({lg_i.k, lg_i.frac});
    plo_d      = l_d * SLOPE_LO;
  end

  always_comb begin
    phi = l_q * SLOPE_HI;
    p_d = (phi <<< SLOPE_SPLIT) + V_BITS'(plo_q);
  end

  always_comb begin
    v     = p_q + OFFSET_Q48;
    whole = v[V_BITS-2:V_POINT];
    if (frc2_q.zero) begin
      code_d = '0;
    end else if (frc2_q.full) begin
      code_d = CODE_MAX;
    end else if (v[V_BITS-1]) begin
      code_d = '0;
    end else if (whole > WHOLE_BITS'(CODE_MAX)) begin
      code_d = CODE_MAX;
    end else begin
      code_d = whole[CODE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    frc1_q <= frc_d;
    l_q    <= l_d;
    plo_q  <= plo_d;
    frc2_q <= frc1_q;
    p_q    <= p_d;
    code_q <= code_d;
  end

  assign code_o = code_q;

endmodule

[rtl/core/stereo_peak_db_meter_packer_top.sv]
// Stereo peak meter: two linear peak magnitudes in, one five-byte dB meter message out.
// Input channel: a transaction is taken at a rising edge with start high and busy low.
//   busy stays low, so a new event can be taken in every cycle.
// Config: cfg_we_i writes cfg_wdata_i into the meter enable at the rising edge; events
//   taken while the enable is low produce no message.
// Output channel: done_o is high for one cycle with the message on result_o; the message
//   is taken at the edge that ends that cycle and cannot be held off.
// Pipeline: from the accepting edge to the edge that takes the message, an event passes one
//   normalize stage, 24 squaring stages of the log2 unit (one fraction bit per 32x32
//   multiply) and three stages of constant scaling and clamping. Throughput: one event
//   per cycle, set by the fully pipelined squaring chain.
// Reset (rst_ni low, asynchronous) clears the enable and all pipeline valid bits, so
//   events in flight are dropped; no message follows reset until new events are taken.
module stereo_peak_db_meter_packer_top import spdm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  peak_in_t   in_i,
  output logic       busy,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  output logic       done_o,
  output meter_out_t result_o
);

  logic                    enable_q;
  logic                    acc;
  logic [LATENCY-1:0]      vld_d, vld_q;
  logic [CHANNEL_BITS-1:0] chan_q [LATENCY];
  logic [PEAK_BITS-1:0]    peak_w [2];
  lg_t                     lg_w   [2][LOG_FRAC_BITS+1];
  logic [CODE_BITS-1:0]    code_w [2];

  assign busy   = 1'b0;
  assign acc    = start && !busy && enable_q;
  assign vld_d  = {vld_q[LATENCY-2:0], acc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      vld_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chan_q[0] <= in_i.channel_number;
    for (int i = 1; i < LATENCY; i++) begin
      chan_q[i] <= chan_q[i-1];
    end
  end

  assign peak_w[0] = in_i.left_peak;
  assign peak_w[1] = in_i.right_peak;

  for (genvar s = 0; s < 2; s++) begin : g_side
    spdm_norm u_norm (
      .clk_i  (clk_i),
      .peak_i (peak_w[s]),
      .lg_o   (lg_w[s][0])
    );

    for (genvar j = 0; j < LOG_FRAC_BITS; j++) begin : g_sq
      spdm_sq_stage u_sq (
        .clk_i (clk_i),
        .lg_i  (lg_w[s][j]),
        .lg_o  (lg_w[s][j+1])
      );
    end

    spdm_scale u_scale (
      .clk_i  (clk_i),
      .lg_i   (lg_w[s][LOG_FRAC_BITS]),
      .code_o (code_w[s])
    );
  end

  assign done_o                    = vld_q[LATENCY-1];
  assign result_o.channel_byte     = chan_q[LATENCY-1];
  assign result_o.left_high_seven  = code_w[0][CODE_BITS-1:SEVEN_BITS];
  assign result_o.left_low_seven   = code_w[0][SEVEN_BITS-1:0];
  assign result_o.right_high_seven = code_w[1][CODE_BITS-1:SEVEN_BITS];
  assign result_o.right_low_seven  = code_w[1][SEVEN_BITS-1:0];

  a_disabled_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !enable_q) |=> !vld_q[0])
    else $error("event entered pipeline while meter disabled");

  a_done_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##LATENCY done_o)
    else $error("accepted transaction produced no message strobe");

  a_done_from_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(acc, LATENCY))
    else $error("message strobe out of step with accepted transaction");

  a_channel_align : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.channel_byte == $past(in_i.channel_number, LATENCY)))
    else $error("channel byte not aligned with its transaction");

endmodule
